// ----- hdl/mp_config_table_parser_unit_assert.svh -----
// Assertion macros shared by the configuration table parser RTL.
// Assertions are compiled in by default and reduce to nothing when SYNTH is defined.
`ifndef MP_CONFIG_TABLE_PARSER_UNIT_ASSERT_SVH
`define MP_CONFIG_TABLE_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define MPCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be true outside reset
`define MPCT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MPCT_ASSERT(label, prop, msg)
`define MPCT_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- hdl/mpct_pkg.sv -----
// Package for the configuration table parser: payload types, status codes,
// header offsets and entry layout constants. No dependencies.
`timescale 1ns / 1ps
package mpct_pkg;

  // processor limit
  localparam int unsigned MaxCpus = 8;

  // byte offset counter
  localparam int unsigned OffW = 17;
  localparam logic [OffW-1:0] OffMax    = '1;
  localparam logic [OffW-1:0] OffSigEnd = OffW'(4);
  localparam logic [OffW-1:0] OffLenLo  = OffW'(4);
  localparam logic [OffW-1:0] OffLenHi  = OffW'(5);
  localparam logic [OffW-1:0] OffVer    = OffW'(6);
  localparam logic [OffW-1:0] OffSumFix = OffW'(6);
  localparam logic [OffW-1:0] OffCntLo  = OffW'(34);
  localparam logic [OffW-1:0] OffCntHi  = OffW'(35);
  localparam logic [OffW-1:0] OffApic0  = OffW'(36);
  localparam logic [OffW-1:0] OffApic1  = OffW'(37);
  localparam logic [OffW-1:0] OffApic2  = OffW'(38);
  localparam logic [OffW-1:0] OffApic3  = OffW'(39);
  localparam logic [OffW-1:0] OffExtLo  = OffW'(40);
  localparam logic [OffW-1:0] OffExtHi  = OffW'(41);
  localparam logic [OffW-1:0] OffExtChk = OffW'(42);
  localparam logic [OffW-1:0] HdrBytes  = OffW'(44);

  // accepted spec revisions
  localparam logic [7:0] VerOld = 8'h01;
  localparam logic [7:0] VerNew = 8'h04;

  // entry layout
  localparam logic [7:0] EntProc      = 8'h00;
  localparam logic [7:0] EntShortLow  = 8'h01;
  localparam logic [7:0] EntShortHigh = 8'h04;
  localparam logic [4:0] ProcLeft     = 5'd19;
  localparam logic [4:0] ShortLeft    = 5'd7;
  localparam logic [4:0] FlagsLeft    = 5'd17;
  localparam int unsigned BootFlagBit = 1;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusSignature   = 3'd1,
    StatusChecksum    = 3'd2,
    StatusVersion     = 3'd3,
    StatusExtChecksum = 3'd4,
    StatusUnknown     = 3'd5,
    StatusTruncated   = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic        smp_enabled;
    logic [3:0]  cpu_count;
    logic [2:0]  boot_cpu;
    logic [31:0] lapic_address;
    logic        too_many_cpus;
  } out_t;

  // entry walk view after the current byte
  typedef struct packed {
    logic       failed;
    logic       pending;
    logic [3:0] cpu_tally;
    logic [2:0] boot_index;
    logic       overflow;
  } walk_t;

  // expected signature byte
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h50;
      2'd1:    v = 8'h43;
      2'd2:    v = 8'h4D;
      default: v = 8'h50;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/mpct_entry_walk.sv -----
// Entry walker: follows processor, bus, I/O APIC and interrupt entries,
// counts processors and records the bootstrap one. Depends on mpct_pkg.
`timescale 1ns / 1ps
module mpct_entry_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  logic [7:0]          data_i,
  input  logic [15:0]         entry_total_i,
  output mpct_pkg::walk_t     walk_o
);

  logic [4:0]  left_q, left_d;
  logic [15:0] done_q, done_d;
  logic [3:0]  tally_q, tally_d;
  logic [2:0]  boot_q, boot_d;
  logic        over_q, over_d;
  logic        failed_q, failed_d;

  // next walk state for one entry byte
  always_comb begin
    left_d   = left_q;
    done_d   = done_q;
    tally_d  = tally_q;
    boot_d   = boot_q;
    over_d   = over_q;
    failed_d = failed_q;
    if (step_i && !failed_q) begin
      if (left_q != 5'd0) begin
        if (left_q == mpct_pkg::FlagsLeft) begin
          if (tally_q < 4'(mpct_pkg::MaxCpus)) begin
            if (data_i[mpct_pkg::BootFlagBit]) begin
              boot_d = tally_q[2:0];
            end
            tally_d = tally_q + 4'd1;
          end else begin
            over_d = 1'b1;
          end
        end
        left_d = left_q - 5'd1;
      end else if (done_q < entry_total_i) begin
        done_d = done_q + 16'd1;
        if (data_i == mpct_pkg::EntProc) begin
          left_d = mpct_pkg::ProcLeft;
        end else if (data_i >= mpct_pkg::EntShortLow && data_i <= mpct_pkg::EntShortHigh) begin
          left_d = mpct_pkg::ShortLeft;
        end else begin
          failed_d = 1'b1;
        end
      end
    end
  end

  // post-update view for the result
  always_comb begin
    walk_o.failed     = failed_d;
    walk_o.pending    = (done_d < entry_total_i) || (left_d != 5'd0);
    walk_o.cpu_tally  = tally_d;
    walk_o.boot_index = boot_d;
    walk_o.overflow   = over_d;
  end

  // walk registers, cleared after each table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      done_q   <= '0;
      tally_q  <= '0;
      boot_q   <= '0;
      over_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (clear_i) begin
      left_q   <= '0;
      done_q   <= '0;
      tally_q  <= '0;
      boot_q   <= '0;
      over_q   <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      left_q   <= left_d;
      done_q   <= done_d;
      tally_q  <= tally_d;
      boot_q   <= boot_d;
      over_q   <= over_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ----- hdl/mp_config_table_parser_unit.sv -----
// Multiprocessor configuration table parser top level.
// Uses mpct_pkg, mpct_entry_walk and mp_config_table_parser_unit_assert.svh.
//
// Usage: table bytes enter on the input channel (in_valid_i / in_ready_o,
// payload in_data_i) one byte per transfer, starting at the first header
// byte. The byte with last_byte set closes the table; one result then
// appears on the output channel (out_valid_o / out_ready_i, payload
// out_data_o). Bytes without last_byte give no result.
// Latency: the result is valid in the cycle after the last byte's transfer.
// Throughput: one byte per cycle while in_ready_o is high; header capture,
// both checksums and the entry walk all update in the same cycle the byte is taken.
// A new table may start in the cycle after the previous last byte.
// Stall: the result waits in the output register; input is still taken
// while out_ready_i is high, and held off only when a result is waiting
// and out_ready_i is low.
// Reset: clears all parse state and drops out_valid_o; the block is ready
// for the first header byte right after reset, and parse state returns to
// the same reset values after every last byte.
`timescale 1ns / 1ps
`include "mp_config_table_parser_unit_assert.svh"
module mp_config_table_parser_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mpct_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mpct_pkg::out_t   out_data_o
);

  logic                      acc;
  logic [7:0]                b;
  logic                      walk_step;
  logic [mpct_pkg::OffW-1:0] ext_end;
  logic [7:0]                ext_total;
  mpct_pkg::walk_t           walk;
  mpct_pkg::out_t            res;

  logic [mpct_pkg::OffW-1:0] off_q, off_d;
  logic [7:0]                base_sum_q, base_sum_d;
  logic [7:0]                ext_sum_q, ext_sum_d;
  logic                      sig_ok_q, sig_ok_d;
  logic [15:0]               tlen_q, tlen_d;
  logic [7:0]                ver_q, ver_d;
  logic [15:0]               etotal_q, etotal_d;
  logic [31:0]               apic_q, apic_d;
  logic [15:0]               elen_q, elen_d;
  logic [7:0]                echk_q, echk_d;
  logic                      out_valid_q;
  mpct_pkg::out_t            out_q;

  // transfer on the input side
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;

  // header capture and checksums
  always_comb begin
    sig_ok_d = sig_ok_q;
    tlen_d   = tlen_q;
    ver_d    = ver_q;
    etotal_d = etotal_q;
    apic_d   = apic_q;
    elen_d   = elen_q;
    echk_d   = echk_q;
    if (off_q < mpct_pkg::OffSigEnd && b != mpct_pkg::sig_byte(off_q[1:0])) begin
      sig_ok_d = 1'b0;
    end
    case (off_q)
      mpct_pkg::OffLenLo:  tlen_d[7:0]    = b;
      mpct_pkg::OffLenHi:  tlen_d[15:8]   = b;
      mpct_pkg::OffVer:    ver_d          = b;
      mpct_pkg::OffCntLo:  etotal_d[7:0]  = b;
      mpct_pkg::OffCntHi:  etotal_d[15:8] = b;
      mpct_pkg::OffApic0:  apic_d[7:0]    = b;
      mpct_pkg::OffApic1:  apic_d[15:8]   = b;
      mpct_pkg::OffApic2:  apic_d[23:16]  = b;
      mpct_pkg::OffApic3:  apic_d[31:24]  = b;
      mpct_pkg::OffExtLo:  elen_d[7:0]    = b;
      mpct_pkg::OffExtHi:  elen_d[15:8]   = b;
      mpct_pkg::OffExtChk: echk_d         = b;
      default: ;
    endcase

    ext_end = {1'b0, tlen_d} + {1'b0, elen_d};

    base_sum_d = base_sum_q;
    if (off_q < mpct_pkg::OffSumFix || off_q < {1'b0, tlen_d}) begin
      base_sum_d = base_sum_q + b;
    end
    ext_sum_d = ext_sum_q;
    if (off_q >= mpct_pkg::OffSumFix && off_q >= {1'b0, tlen_d} && off_q < ext_end) begin
      ext_sum_d = ext_sum_q + b;
    end

    off_d = (off_q != mpct_pkg::OffMax) ? off_q + 1'b1 : off_q;
  end

  assign walk_step = acc && (off_q >= mpct_pkg::HdrBytes);

  mpct_entry_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (walk_step),
    .clear_i       (acc && in_data_i.last_byte),
    .data_i        (b),
    .entry_total_i (etotal_q),
    .walk_o        (walk)
  );

  // verdict on the table, first failing check wins
  assign ext_total = ext_sum_d + echk_d;
  always_comb begin
    res = '0;
    res.status = mpct_pkg::StatusOk;
    if (off_d < mpct_pkg::OffSigEnd) begin
      res.status = mpct_pkg::StatusTruncated;
    end else if (!sig_ok_d) begin
      res.status = mpct_pkg::StatusSignature;
    end else if (off_d < mpct_pkg::OffSumFix) begin
      res.status = mpct_pkg::StatusTruncated;
    end else if ({1'b0, tlen_d} < mpct_pkg::HdrBytes) begin
      res.status = mpct_pkg::StatusChecksum;
    end else if (off_d < {1'b0, tlen_d}) begin
      res.status = mpct_pkg::StatusTruncated;
    end else if (base_sum_d != 8'd0) begin
      res.status = mpct_pkg::StatusChecksum;
    end else if (ver_d != mpct_pkg::VerOld && ver_d != mpct_pkg::VerNew) begin
      res.status = mpct_pkg::StatusVersion;
    end else if (off_d < ext_end) begin
      res.status = mpct_pkg::StatusTruncated;
    end else if (ext_total != 8'd0) begin
      res.status = mpct_pkg::StatusExtChecksum;
    end else if (walk.failed) begin
      res.status        = mpct_pkg::StatusUnknown;
      res.cpu_count     = 4'd1;
      res.boot_cpu      = walk.boot_index;
      res.too_many_cpus = walk.overflow;
    end else if (walk.pending) begin
      res.status = mpct_pkg::StatusTruncated;
    end else begin
      res.smp_enabled   = 1'b1;
      res.cpu_count     = walk.cpu_tally;
      res.boot_cpu      = walk.boot_index;
      res.lapic_address = apic_d;
      res.too_many_cpus = walk.overflow;
    end
  end

  // parse state, back to reset values after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      base_sum_q <= '0;
      ext_sum_q  <= '0;
      sig_ok_q   <= 1'b1;
      tlen_q     <= '0;
      ver_q      <= '0;
      etotal_q   <= '0;
      apic_q     <= '0;
      elen_q     <= '0;
      echk_q     <= '0;
    end else if (acc) begin
      if (in_data_i.last_byte) begin
        off_q      <= '0;
        base_sum_q <= '0;
        ext_sum_q  <= '0;
        sig_ok_q   <= 1'b1;
        tlen_q     <= '0;
        ver_q      <= '0;
        etotal_q   <= '0;
        apic_q     <= '0;
        elen_q     <= '0;
        echk_q     <= '0;
      end else begin
        off_q      <= off_d;
        base_sum_q <= base_sum_d;
        ext_sum_q  <= ext_sum_d;
        sig_ok_q   <= sig_ok_d;
        tlen_q     <= tlen_d;
        ver_q      <= ver_d;
        etotal_q   <= etotal_d;
        apic_q     <= apic_d;
        elen_q     <= elen_d;
        echk_q     <= echk_d;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.last_byte) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `MPCT_ASSERT(a_last_gives_result, (acc && in_data_i.last_byte) |=> out_valid_q, "last byte without result")
  `MPCT_ASSERT_NEVER(a_smp_needs_ok, out_valid_q && out_q.smp_enabled && out_q.status != mpct_pkg::StatusOk, "smp enabled on failed table")
  `MPCT_ASSERT_NEVER(a_unknown_one_cpu, out_valid_q && out_q.status == mpct_pkg::StatusUnknown && out_q.cpu_count != 4'd1, "unknown entry count not one")
  `MPCT_ASSERT_NEVER(a_lapic_cleared, out_valid_q && !out_q.smp_enabled && out_q.lapic_address != 32'd0, "apic address kept without smp")
  `MPCT_ASSERT(a_offset_advances, (acc && !in_data_i.last_byte) |=> (off_q != '0), "offset not advanced")

endmodule
